/* design/fhc_pkg.sv */
package fhc_pkg;

   localparam logic [7:0] LEN_SHORT = 8'd12;
   localparam logic [7:0] LEN_LONG  = 8'd14;

   // ".FIT" in byte order
   localparam logic [7:0] MAGIC_CHARS [4] = '{8'h2E, 8'h46, 8'h49, 8'h54};

   typedef enum logic [2:0] {
      ST_NO_CRC   = 3'd0,
      ST_CRC_ZERO = 3'd1,
      ST_CRC_OK   = 3'd2,
      ST_CRC_BAD  = 3'd3,
      ST_BAD_LEN  = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  header_length;
      logic [7:0]  proto_rev;
      logic [15:0] profile_rev;
      logic [31:0] record_bytes;
      logic        magic_ok;
      logic [15:0] computed_crc;
      logic [15:0] stored_crc;
   } result_type;

   function automatic logic [15:0] nib_tab(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'h0: val = 16'h0000;
         4'h1: val = 16'hCC01;
         4'h2: val = 16'hD801;
         4'h3: val = 16'h1400;
         4'h4: val = 16'hF001;
         4'h5: val = 16'h3C00;
         4'h6: val = 16'h2800;
         4'h7: val = 16'hE401;
         4'h8: val = 16'hA001;
         4'h9: val = 16'h6C00;
         4'hA: val = 16'h7800;
         4'hB: val = 16'hB401;
         4'hC: val = 16'h5000;
         4'hD: val = 16'h9C01;
         4'hE: val = 16'h8801;
         4'hF: val = 16'h4400;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

   function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
      logic [15:0] tmp;
      tmp = nib_tab(crc[3:0]);
      return ({4'h0, crc[15:4]} ^ tmp ^ nib_tab(nib));
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] mid;
      mid = crc_nibble(crc, data[3:0]);
      return crc_nibble(mid, data[7:4]);
   endfunction

endpackage

/* design/fhc_parse.sv */
module fhc_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic [7:0]           data_byte,
   input  logic                 file_start,
   output logic                 res_valid,
   output fhc_pkg::result_type  res
);

   logic        in_header_ff, in_header_in;
   logic [3:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  size_byte_ff, size_byte_in;
   logic [7:0]  protocol_byte_ff, protocol_byte_in;
   logic [15:0] profile_word_ff, profile_word_in;
   logic [31:0] size_word_ff, size_word_in;
   logic        magic_match_ff, magic_match_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] stored_crc_ff, stored_crc_in;
   logic [3:0]  pos;

   assign pos = bytes_seen_ff;

   always_comb begin
      in_header_in     = in_header_ff;
      bytes_seen_in    = bytes_seen_ff;
      size_byte_in     = size_byte_ff;
      protocol_byte_in = protocol_byte_ff;
      profile_word_in  = profile_word_ff;
      size_word_in     = size_word_ff;
      magic_match_in   = magic_match_ff;
      running_crc_in   = running_crc_ff;
      stored_crc_in    = stored_crc_ff;
      res_valid        = 1'b0;
      res              = '0;
      res.status       = fhc_pkg::ST_NO_CRC;

      if (item_valid && file_start) begin
         bytes_seen_in    = 4'd0;
         size_byte_in     = data_byte;
         protocol_byte_in = 8'd0;
         profile_word_in  = 16'd0;
         size_word_in     = 32'd0;
         stored_crc_in    = 16'd0;
         running_crc_in   = 16'd0;
         if (!(data_byte inside {fhc_pkg::LEN_SHORT, fhc_pkg::LEN_LONG})) begin
            in_header_in      = 1'b0;
            magic_match_in    = 1'b0;
            res_valid         = 1'b1;
            res.status        = fhc_pkg::ST_BAD_LEN;
            res.header_length = data_byte;
         end else begin
            in_header_in   = 1'b1;
            magic_match_in = 1'b1;
            running_crc_in = fhc_pkg::crc_byte(16'd0, data_byte);
            bytes_seen_in  = 4'd1;
         end
      end else if (item_valid && in_header_ff) begin
         if (pos < 4'd12) begin
            running_crc_in = fhc_pkg::crc_byte(running_crc_ff, data_byte);
         end
         if (pos == 4'd1) begin
            protocol_byte_in = data_byte;
         end else if (pos == 4'd2) begin
            profile_word_in[7:0] = data_byte;
         end else if (pos == 4'd3) begin
            profile_word_in[15:8] = data_byte;
         end else if (pos inside {[4'd4:4'd7]}) begin
            size_word_in[{pos[1:0], 3'b000} +: 8] = data_byte;
         end else if (pos inside {[4'd8:4'd11]}) begin
            if (data_byte != fhc_pkg::MAGIC_CHARS[pos[1:0]]) begin
               magic_match_in = 1'b0;
            end
         end else if (pos == 4'd12) begin
            stored_crc_in = {8'd0, data_byte};
         end else if (pos == 4'd13) begin
            stored_crc_in[15:8] = data_byte;
         end
         bytes_seen_in = pos + 4'd1;

         res.header_length = size_byte_ff;
         res.proto_rev     = protocol_byte_in;
         res.profile_rev   = profile_word_in;
         res.record_bytes  = size_word_in;
         res.magic_ok      = magic_match_in;
         res.computed_crc  = running_crc_in;
         res.stored_crc    = stored_crc_in;

         if (size_byte_ff == fhc_pkg::LEN_SHORT && pos == 4'd11) begin
            in_header_in = 1'b0;
            res_valid    = 1'b1;
            res.status   = fhc_pkg::ST_NO_CRC;
         end else if (size_byte_ff == fhc_pkg::LEN_LONG && pos == 4'd13) begin
            in_header_in = 1'b0;
            res_valid    = 1'b1;
            if (stored_crc_in == 16'd0) begin
               res.status = fhc_pkg::ST_CRC_ZERO;
            end else if (stored_crc_in == running_crc_in) begin
               res.status = fhc_pkg::ST_CRC_OK;
            end else begin
               res.status = fhc_pkg::ST_CRC_BAD;
            end
         end else if (pos >= 4'd13) begin
            in_header_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff     <= 1'b0;
         bytes_seen_ff    <= 4'd0;
         size_byte_ff     <= 8'd0;
         protocol_byte_ff <= 8'd0;
         profile_word_ff  <= 16'd0;
         size_word_ff     <= 32'd0;
         magic_match_ff   <= 1'b1;
         running_crc_ff   <= 16'd0;
         stored_crc_ff    <= 16'd0;
      end else begin
         in_header_ff     <= in_header_in;
         bytes_seen_ff    <= bytes_seen_in;
         size_byte_ff     <= size_byte_in;
         protocol_byte_ff <= protocol_byte_in;
         profile_word_ff  <= profile_word_in;
         size_word_ff     <= size_word_in;
         magic_match_ff   <= magic_match_in;
         running_crc_ff   <= running_crc_in;
         stored_crc_ff    <= stored_crc_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      in_header_ff |-> (bytes_seen_ff != 4'd0 && bytes_seen_ff <= 4'd13))
      else $error("header position out of range");

   a_len_known: assert property (@(posedge clock) disable iff (reset)
      in_header_ff |->
         (size_byte_ff == fhc_pkg::LEN_SHORT || size_byte_ff == fhc_pkg::LEN_LONG))
      else $error("collecting a header of unsupported length");

   a_res_source: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !file_start) |-> in_header_ff)
      else $error("result outside a header");

endmodule

/* design/fhc_out_buf.sv */
module fhc_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fhc_pkg::result_type  in_res,
   output logic                 in_full,
   output logic                 out_valid,
   output fhc_pkg::result_type  out_res,
   input  logic                 out_stall
);

   logic                out_valid_ff;
   fhc_pkg::result_type out_res_ff;
   logic                skid_valid_ff;
   fhc_pkg::result_type skid_res_ff;
   logic                out_free;

   assign out_free  = !out_valid_ff || !out_stall;
   assign in_full   = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_res_ff <= skid_res_ff;
         end else if (in_valid) begin
            out_res_ff <= in_res;
         end
      end else if (in_valid) begin
         skid_res_ff <= in_res;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result ahead of the output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result arrived with both stages full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid stage failed to drain");

endmodule

/* design/fit_header_check_unit.sv */
// FIT file header checker.
//
// Request channel (req_*): one file byte per transfer, req_file_start set on
// byte 0 of each file. Byte 0 is the header length; a length other than 12
// or 14 gives a bad-length result straight away. Otherwise bytes 1 to 11
// (and 12, 13 for the long header) are collected, the CRC-16 is run over
// bytes 0 to 11 and one result is produced on the last header byte. Bytes
// past the header, or bytes with no file started, produce nothing. A new
// start inside a header drops the unfinished one silently.
// Response channel (rsp_*): one transfer per header, fields as collected.
// Timing: one byte per cycle while req_stall is low. The last header byte's
// result passes a CRC step of two nibble steps, two table lookups each, from
// the header state into the output register, or the skid stage if stalled.
// Stall: an output register plus a one-entry skid stage sit on the response
// side, so bytes keep flowing while one result waits; req_stall rises only
// once the skid stage is also occupied and is a pure register output.
// Reset (synchronous, active high) returns to idle with both stages empty.
module fit_header_check_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_header_length,
   output logic [7:0]  rsp_proto_rev,
   output logic [15:0] rsp_profile_rev,
   output logic [31:0] rsp_record_bytes,
   output logic        rsp_magic_ok,
   output logic [15:0] rsp_computed_crc,
   output logic [15:0] rsp_stored_crc
);

   logic                req_take;
   logic                res_valid;
   fhc_pkg::result_type res;
   fhc_pkg::result_type rsp_res;

   // byte transfer on the request side
   assign req_take = req_valid && !req_stall;

   fhc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_take),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .res_valid  (res_valid),
      .res        (res)
   );

   // output register and skid stage; full skid stage back-pressures bytes
   fhc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_full   (req_stall),
      .out_valid (rsp_valid),
      .out_res   (rsp_res),
      .out_stall (rsp_stall)
   );

   assign rsp_status        = rsp_res.status;
   assign rsp_header_length = rsp_res.header_length;
   assign rsp_proto_rev     = rsp_res.proto_rev;
   assign rsp_profile_rev   = rsp_res.profile_rev;
   assign rsp_record_bytes  = rsp_res.record_bytes;
   assign rsp_magic_ok      = rsp_res.magic_ok;
   assign rsp_computed_crc  = rsp_res.computed_crc;
   assign rsp_stored_crc    = rsp_res.stored_crc;

endmodule

/* bench/fhc_check_pkg.sv */
package fhc_check_pkg;

   // FIT nibble table, one entry per low nibble of the running value
   localparam logic [15:0] NIBBLE_LUT [16] = '{
      16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
      16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
   };

   // low nibble first, then high nibble
   function automatic logic [15:0] crc16_fold_byte(input logic [15:0] acc,
                                                    input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      r = {4'h0, r[15:4]} ^ NIBBLE_LUT[r[3:0]] ^ NIBBLE_LUT[b[3:0]];
      r = {4'h0, r[15:4]} ^ NIBBLE_LUT[r[3:0]] ^ NIBBLE_LUT[b[7:4]];
      return r;
   endfunction

   class header_tracker;

      // header under collection
      bit          in_hdr;
      int          pos;
      logic [7:0]  len_byte;
      logic [7:0]  proto;
      logic [15:0] profile;
      logic [31:0] dsize;
      bit          magic;
      logic [15:0] crc;
      logic [15:0] stored;

      fhc_pkg::result_type due_headers [$];
      int                  bad_count;

      function new();
         clear();
         bad_count = 0;
      endfunction

      function void clear();
         in_hdr   = 1'b0;
         pos      = 0;
         len_byte = '0;
         proto    = '0;
         profile  = '0;
         dsize    = '0;
         magic    = 1'b1;
         crc      = '0;
         stored   = '0;
      endfunction

      function void queue_header(input fhc_pkg::status_type st);
         fhc_pkg::result_type r;
         r.status        = st;
         r.header_length = len_byte;
         r.proto_rev     = proto;
         r.profile_rev   = profile;
         r.record_bytes  = dsize;
         r.magic_ok      = magic;
         r.computed_crc  = crc;
         r.stored_crc    = stored;
         due_headers.push_back(r);
      endfunction

      function int pending();
         return due_headers.size();
      endfunction

      // one accepted byte transfer
      function void take_byte(input logic [7:0] b, input logic start);
         int p;
         if (start) begin
            clear();
            len_byte = b;
            if (!(b inside {fhc_pkg::LEN_SHORT, fhc_pkg::LEN_LONG})) begin
               magic = 1'b0;
               queue_header(fhc_pkg::ST_BAD_LEN);
               return;
            end
            in_hdr = 1'b1;
            crc    = crc16_fold_byte(16'h0000, b);
            pos    = 1;
            return;
         end
         if (!in_hdr) return;

         p = pos;
         if (p < 12) crc = crc16_fold_byte(crc, b);
         if (p == 1) begin
            proto = b;
         end else if (p inside {[2:3]}) begin
            profile[8*(p-2) +: 8] = b;
         end else if (p inside {[4:7]}) begin
            dsize[8*(p-4) +: 8] = b;
         end else if (p inside {[8:11]}) begin
            if (b != fhc_pkg::MAGIC_CHARS[p-8]) magic = 1'b0;
         end else if (p == 12) begin
            stored[7:0] = b;
         end else if (p == 13) begin
            stored[15:8] = b;
         end
         pos = (p + 1) & 15;

         if (len_byte == fhc_pkg::LEN_SHORT && p == 11) begin
            in_hdr = 1'b0;
            queue_header(fhc_pkg::ST_NO_CRC);
         end else if (len_byte == fhc_pkg::LEN_LONG && p == 13) begin
            in_hdr = 1'b0;
            if (stored == 16'h0000)   queue_header(fhc_pkg::ST_CRC_ZERO);
            else if (stored == crc)   queue_header(fhc_pkg::ST_CRC_OK);
            else                      queue_header(fhc_pkg::ST_CRC_BAD);
         end else if (p >= 13) begin
            in_hdr = 1'b0;
         end
      endfunction

      // one accepted result transfer against the oldest header due
      function void match_header(input fhc_pkg::result_type seen);
         fhc_pkg::result_type want;
         bit diff;
         if (due_headers.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result: status %0d len %h", seen.status,
                        seen.header_length);
            return;
         end
         want = due_headers.pop_front();
         diff = (seen.status        !== want.status)
             || (seen.header_length !== want.header_length)
             || (seen.proto_rev     !== want.proto_rev)
             || (seen.profile_rev   !== want.profile_rev)
             || (seen.record_bytes  !== want.record_bytes)
             || (seen.magic_ok      !== want.magic_ok)
             || (seen.computed_crc  !== want.computed_crc)
             || (seen.stored_crc    !== want.stored_crc);
         if (diff) begin
            bad_count++;
            if (bad_count <= 10) begin
               $display("mismatch exp/got: status %0d/%0d len %h/%h proto %h/%h prof %h/%h",
                        want.status, seen.status, want.header_length, seen.header_length,
                        want.proto_rev, seen.proto_rev,
                        want.profile_rev, seen.profile_rev);
               $display("   size %h/%h magic %b/%b crc %h/%h stored %h/%h",
                        want.record_bytes, seen.record_bytes, want.magic_ok, seen.magic_ok,
                        want.computed_crc, seen.computed_crc,
                        want.stored_crc, seen.stored_crc);
            end
         end
      endfunction

   endclass

endpackage

/* bench/tb_top.sv */
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // watchdog: cycles with no transfer on either channel
   localparam int QUIET_LIMIT  = 2000;
   // margin of idle cycles before finishing once every result is back
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET  = 650;
   localparam int QUIET_AFTER  = 550;   // no idling past this many items
   localparam int PAUSE_AT     = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_file_start = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_header_length;
   logic [7:0]  rsp_proto_rev;
   logic [15:0] rsp_profile_rev;
   logic [31:0] rsp_record_bytes;
   logic        rsp_magic_ok;
   logic [15:0] rsp_computed_crc;
   logic [15:0] rsp_stored_crc;

   fhc_check_pkg::header_tracker tracker;
   fhc_pkg::result_type          seen;
   bit            gaps_on    = 1'b1;
   bit            paused     = 1'b0;
   bit            moved;
   int            quiet      = 0;
   int            stall_left = 0;
   int            items      = 0;

   fit_header_check_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_file_start    (req_file_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_header_length (rsp_header_length),
      .rsp_proto_rev     (rsp_proto_rev),
      .rsp_profile_rev   (rsp_profile_rev),
      .rsp_record_bytes  (rsp_record_bytes),
      .rsp_magic_ok      (rsp_magic_ok),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_stored_crc    (rsp_stored_crc)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Transfers are seen at the rising edge, before any register of the
   // block takes its new value. Both channels are monitored here, and the
   // watchdog runs off the same edge.
   always @(posedge clock) begin
      moved = 1'b0;
      if (req_valid && !req_stall) begin
         tracker.take_byte(req_data_byte, req_file_start);
         moved = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
         seen.status        = fhc_pkg::status_type'(rsp_status);
         seen.header_length = rsp_header_length;
         seen.proto_rev     = rsp_proto_rev;
         seen.profile_rev   = rsp_profile_rev;
         seen.record_bytes  = rsp_record_bytes;
         seen.magic_ok      = rsp_magic_ok;
         seen.computed_crc  = rsp_computed_crc;
         seen.stored_crc    = rsp_stored_crc;
         tracker.match_header(seen);
         moved = 1'b1;
      end
      if (moved) begin
         quiet <= 0;
      end else if (!reset) begin
         if (quiet + 1 >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         quiet <= quiet + 1;
      end
   end

   // Receiver: stall in random bursts, none once gaps are off.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Called and returns at a falling edge. Valid stays high from one
   // transfer to the next unless an idle burst is put in between.
   task automatic send_byte(input logic [7:0] b, input logic start);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_file_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // field bytes lean towards the extremes now and then
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One file header: mostly well formed with random content; some with a
   // bad length, a spoilt magic, a wrong or zero CRC, or cut short.
   task automatic send_header();
      logic [7:0]  hdr [14];
      logic [15:0] crc;
      int          sel, len, cut, idx, tail;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         hdr[0] = pick_byte();
         if (hdr[0] inside {fhc_pkg::LEN_SHORT, fhc_pkg::LEN_LONG}) hdr[0] ^= 8'h01;
         len = 1;
      end else begin
         len    = (sel < 50) ? 12 : 14;
         hdr[0] = 8'(len);
         for (int i = 1; i < 8; i++) hdr[i] = pick_byte();
         for (int i = 0; i < 4; i++) hdr[8+i] = fhc_pkg::MAGIC_CHARS[i];
         if ($urandom_range(0, 99) < 15) begin
            idx = 8 + $urandom_range(0, 3);
            hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
         end
         crc = 16'h0000;
         for (int i = 0; i < 12; i++) crc = fhc_check_pkg::crc16_fold_byte(crc, hdr[i]);
         case ($urandom_range(0, 9))
            0, 1, 2: crc = 16'h0000;
            8, 9:    crc = 16'($urandom_range(0, 65535));
            default: ;
         endcase
         hdr[12] = crc[7:0];
         hdr[13] = crc[15:8];
      end
      cut = (len > 1 && $urandom_range(0, 99) < 8) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < cut; i++) send_byte(hdr[i], i == 0);
      items += cut;
      // trailing bytes: ignored after a result, or carry on a cut header
      if ($urandom_range(0, 99) < 15) begin
         tail = $urandom_range(1, 3);
         repeat (tail) send_byte(8'($urandom_range(0, 255)), 1'b0);
         items += tail;
      end
   endtask

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bad lengths at both ends and next to a legal one
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'd13, 1'b1);
      // a byte with no file started
      send_byte(8'hA5, 1'b0);
      // long header abandoned by a fresh start
      send_byte(fhc_pkg::LEN_LONG, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // short header, all fields at their maximum
      send_byte(fhc_pkg::LEN_SHORT, 1'b1);
      repeat (7) send_byte(8'hFF, 1'b0);
      for (int i = 0; i < 4; i++) send_byte(fhc_pkg::MAGIC_CHARS[i], 1'b0);
      // past the header: ignored
      send_byte(8'h00, 1'b0);
      items = 20;

      // random part
      while (items < ITEM_TARGET) begin
         if (items >= QUIET_AFTER) gaps_on = 1'b0;
         if ($urandom_range(0, 99) < 5) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            items++;
         end else begin
            send_header();
         end
         if (!paused && items >= PAUSE_AT) begin
            // hold the sender until every header due has come back
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(negedge clock); while (tracker.pending() != 0);
         end
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.bad_count == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
